/* hw/rtl/vwalu_pkg.sv */
// Package with opcodes, status codes, widths and the stage record types of the ALU.
`default_nettype none
package vwalu_pkg;
    localparam int MAX_WIDTH = 64;
    localparam int WW = 7;
    localparam int DIV_STAGES = MAX_WIDTH;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3, OP_MOD = 4'd4,
        OP_SHL = 4'd5, OP_SHR = 4'd6, OP_AND = 4'd7, OP_XOR = 4'd8, OP_OR = 4'd9,
        OP_NOT = 4'd10, OP_NEG = 4'd11, OP_CMP = 4'd12
    } opcode_t;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_DIVZERO = 2'd3;

    localparam logic [1:0] ORD_EQ = 2'd0;
    localparam logic [1:0] ORD_GT = 2'd1;
    localparam logic [1:0] ORD_LT = 2'd2;

    // Item as it leaves the front stage: reduced operands and decoded view.
    typedef struct packed {
        logic [3:0]           op;
        logic [MAX_WIDTH-1:0] a;
        logic [MAX_WIDTH-1:0] b;
        logic [MAX_WIDTH-1:0] m;
        logic                 sgn;
        logic                 neg_a;
        logic [MAX_WIDTH-1:0] div_n;
        logic [MAX_WIDTH-1:0] div_d;
        logic [MAX_WIDTH-1:0] simple_r;
        logic [1:0]           simple_st;
        logic [1:0]           ord;
    } front_t;

    // Result of one item at the back of the pipeline.
    typedef struct packed {
        logic [MAX_WIDTH-1:0] r;
        logic [1:0]           st;
        logic [1:0]           ord;
    } res_t;
endpackage
`default_nettype wire

/* hw/rtl/vwalu_front.sv */
// Front stage: operand reduction, logic, add, shift and compare, divider operand setup.
`default_nettype none
module vwalu_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_v,
    input  wire logic [3:0]                    opcode,
    input  wire logic [vwalu_pkg::MAX_WIDTH-1:0] operand_a,
    input  wire logic [vwalu_pkg::MAX_WIDTH-1:0] operand_b,
    input  wire logic [vwalu_pkg::WW-1:0]      width,
    input  wire logic                          is_signed,
    output logic                               out_v,
    output vwalu_pkg::front_t                  out_d
);
    import vwalu_pkg::*;

    localparam int SW = $clog2(MAX_WIDTH);
    logic [WW-1:0] w;
    logic [MAX_WIDTH-1:0] m, a, b, top, x, y, r, t, sx, sy;
    logic big;
    logic [1:0] st, ord;
    front_t d;
    logic v_reg;
    front_t d_reg;

    always_comb
    begin
        w = width;
        if (w == '0)
            w = WW'(1);
        if (w > WW'(MAX_WIDTH))
            w = WW'(MAX_WIDTH);
        m = (w >= WW'(MAX_WIDTH)) ? '1 : ((MAX_WIDTH'(1) << w) - MAX_WIDTH'(1));
        a = operand_a & m;
        b = operand_b & m;
        top = MAX_WIDTH'(1) << (w - WW'(1));
        sx = (a ^ top) - top;
        sy = (b ^ top) - top;
        big = (b >= MAX_WIDTH'(MAX_WIDTH));
        r = '0;
        st = ST_OK;
        ord = ORD_EQ;
        t = '0;
        x = '0;
        y = '0;
        case (opcode)
            OP_ADD:
            begin
                r = (a + b) & m;
                if (r < a) st = ST_OVERFLOW;
            end
            OP_SUB:
            begin
                r = (a - b) & m;
                if (r > a) st = ST_UNDERFLOW;
            end
            OP_SHL:
            begin
                r = big ? '0 : ((a << b[SW-1:0]) & m);
                t = big ? '0 : (r >> b[SW-1:0]);
                if (t != a) st = ST_OVERFLOW;
            end
            OP_SHR:
            begin
                r = big ? '0 : (a >> b[SW-1:0]);
                t = big ? '0 : (r << b[SW-1:0]);
                if (t != a) st = ST_UNDERFLOW;
            end
            OP_AND: r = a & b;
            OP_XOR: r = a ^ b;
            OP_OR:  r = a | b;
            OP_NOT: r = ~a & m;
            OP_NEG: r = (MAX_WIDTH'(0) - a) & m;
            OP_CMP:
            begin
                x = is_signed ? {~sx[MAX_WIDTH-1], sx[MAX_WIDTH-2:0]} : a;
                y = is_signed ? {~sy[MAX_WIDTH-1], sy[MAX_WIDTH-2:0]} : b;
                ord = (x == y) ? ORD_EQ : ((x > y) ? ORD_GT : ORD_LT);
            end
            default: r = '0;
        endcase
        d.op = opcode;
        d.a = a;
        d.b = b;
        d.m = m;
        d.sgn = is_signed;
        d.simple_r = r;
        d.simple_st = st;
        d.ord = ord;
        // Signed mod works on magnitudes; the remainder takes the sign of a.
        d.neg_a = (opcode == OP_MOD) && is_signed && sx[MAX_WIDTH-1];
        if ((opcode == OP_MOD) && is_signed)
        begin
            d.div_n = sx[MAX_WIDTH-1] ? (MAX_WIDTH'(0) - sx) : sx;
            d.div_d = sy[MAX_WIDTH-1] ? (MAX_WIDTH'(0) - sy) : sy;
        end
        else
        begin
            d.div_n = a;
            d.div_d = b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= in_v;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= d;
    end

    assign out_v = v_reg;
    assign out_d = d_reg;
endmodule
`default_nettype wire

/* hw/rtl/vwalu_divpipe.sv */
// Pipelined restoring divider, one quotient bit per stage, with a multiplier alongside.
`default_nettype none
module vwalu_divpipe (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_v,
    input  wire vwalu_pkg::front_t in_d,
    output logic                   out_v,
    output vwalu_pkg::res_t        out_d
);
    import vwalu_pkg::*;

    localparam int N = DIV_STAGES;
    localparam int HW = MAX_WIDTH / 2;

    // Per-stage division state; the item record rides along.
    logic [N:0]   v_reg;
    front_t       f_reg [N+1];
    logic [N-1:0] q_reg [N+1];
    logic [N-1:0] rem_reg [N+1];
    logic [N-1:0] num_reg [N+1];

    // Multiplier: four 32x32 partial products across the first stages.
    logic [N-1:0] p_ll_reg, p_lh_reg, p_hl_reg, p_hh_reg;
    logic [N-1:0] mul_lo_reg;
    logic         mul_hi_nz_reg;
    logic [N-1:0] mul_r_reg;
    logic [1:0]   mul_st_reg;
    logic [N-1:0] mul_keep_reg [N+1];
    logic [1:0]   mst_keep_reg [N+1];

    logic [N:0]   trial [N];
    logic [N-1:0] shifted [N];

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            shifted[i] = {rem_reg[i][N-2:0], num_reg[i][N-1]};
            trial[i] = {1'b0, rem_reg[i][N-2:0], num_reg[i][N-1]} - {1'b0, f_reg[i].div_d};
            if (rem_reg[i][N-1])
                trial[i][N] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[N-1:0], in_v};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_reg[0] <= in_d;
            q_reg[0] <= '0;
            rem_reg[0] <= '0;
            num_reg[0] <= in_d.div_n;
            p_ll_reg <= N'(in_d.a[HW-1:0] * in_d.b[HW-1:0]);
            p_lh_reg <= N'(in_d.a[HW-1:0] * in_d.b[N-1:HW]);
            p_hl_reg <= N'(in_d.a[N-1:HW] * in_d.b[HW-1:0]);
            p_hh_reg <= N'(in_d.a[N-1:HW] * in_d.b[N-1:HW]);
            for (int i = 0; i < N; i++)
            begin
                f_reg[i+1] <= f_reg[i];
                num_reg[i+1] <= {num_reg[i][N-2:0], 1'b0};
                if (!trial[i][N])
                begin
                    rem_reg[i+1] <= trial[i][N-1:0];
                    q_reg[i+1] <= {q_reg[i][N-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i+1] <= shifted[i];
                    q_reg[i+1] <= {q_reg[i][N-2:0], 1'b0};
                end
            end
            // Stage 1: low 64 bits of product and whether the high half is nonzero.
            mul_lo_reg <= p_ll_reg + {p_lh_reg[HW-1:0], HW'(0)} + {p_hl_reg[HW-1:0], HW'(0)};
            mul_hi_nz_reg <= (p_hh_reg != '0) || (p_lh_reg[N-1:HW] != '0)
                || (p_hl_reg[N-1:HW] != '0)
                || ((N+2)'(p_ll_reg) + (N+2)'({p_lh_reg[HW-1:0], HW'(0)})
                    + (N+2)'({p_hl_reg[HW-1:0], HW'(0)})) >= (N+2)'({2'b01, N'(0)});
            // Stage 2: masked result; overflow when the product does not fit the width.
            mul_r_reg <= mul_lo_reg & f_reg[1].m;
            mul_st_reg <= (mul_hi_nz_reg || ((mul_lo_reg & ~f_reg[1].m) != '0))
                ? ST_OVERFLOW : ST_OK;
            // The kept product at index i lines up with the record in f_reg[i].
            mul_keep_reg[3] <= mul_r_reg;
            mst_keep_reg[3] <= mul_st_reg;
            for (int i = 3; i < N; i++)
            begin
                mul_keep_reg[i+1] <= mul_keep_reg[i];
                mst_keep_reg[i+1] <= mst_keep_reg[i];
            end
        end
    end

    // Final selection at the end of the divider.
    always_comb
    begin
        front_t f;
        logic [N-1:0] rm;
        f = f_reg[N];
        rm = rem_reg[N];
        out_d.r = f.simple_r;
        out_d.st = f.simple_st;
        out_d.ord = f.ord;
        case (f.op)
            OP_MUL:
            begin
                out_d.r = mul_keep_reg[N];
                out_d.st = mst_keep_reg[N];
            end
            OP_DIV:
            begin
                out_d.r = (f.b == '0) ? f.a : (q_reg[N] & f.m);
                out_d.st = (f.b == '0) ? ST_DIVZERO : ST_OK;
            end
            OP_MOD:
            begin
                out_d.r = (f.b == '0) ? f.a
                    : ((f.neg_a ? (N'(0) - rm) : rm) & f.m);
                out_d.st = (f.b == '0) ? ST_DIVZERO : ST_OK;
            end
            default: out_d.r = f.simple_r;
        endcase
    end

    assign out_v = v_reg[N];
endmodule
`default_nettype wire

/* hw/rtl/variable_width_integer_alu_top.sv */
// Top level of the variable width integer ALU: front stage, divider pipeline, output register.
`default_nettype none
// The ALU accepts one beat per cycle while not stalled and returns the results in order; each
// beat passes the front register, then the restoring divider, which resolves one quotient bit
// per stage over 64 stages, then the output register; every opcode takes the same path, so results
// never reorder. Stall from the output side freezes the whole pipeline; the output register is
// written as long as it is empty or being taken, so while a result waits under stall the input
// is stalled as well, bubbles in earlier stages included. Multiplication overflow is reported
// when the full product does not fit in the width, which is the same as the unsigned check
// that the quotient of the wrapped product by operand a differs from operand b.
module variable_width_integer_alu_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [3:0]  opcode,
    input  wire logic [63:0] operand_a,
    input  wire logic [63:0] operand_b,
    input  wire logic [6:0]  width,
    input  wire logic        is_signed,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      result,
    output logic [1:0]       status,
    output logic [1:0]       order
);
    import vwalu_pkg::*;

    logic en;
    logic f_v, p_v;
    front_t f_d;
    res_t p_d;
    logic v_reg;
    res_t d_reg;

    // The pipeline advances when the output register is empty or drained this cycle.
    assign en = !v_reg || !out_stall;
    assign in_stall = !en;

    vwalu_front u_front (
        .clk(clk), .rst_n(rst_n), .en(en), .in_v(in_valid),
        .opcode(opcode), .operand_a(operand_a), .operand_b(operand_b),
        .width(width), .is_signed(is_signed), .out_v(f_v), .out_d(f_d)
    );

    vwalu_divpipe u_div (
        .clk(clk), .rst_n(rst_n), .en(en), .in_v(f_v), .in_d(f_d),
        .out_v(p_v), .out_d(p_d)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= p_v;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= p_d;
    end

    assign out_valid = v_reg;
    assign result = d_reg.r;
    assign status = d_reg.st;
    assign order = d_reg.ord;
endmodule
`default_nettype wire

/* sim/vwalu_checker.sv */
// Checker that predicts every ALU result from the input channel and compares it with the output channel.
`timescale 1ns / 1ps
module vwalu_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [3:0]  opcode,
    input  wire logic [63:0] operand_a,
    input  wire logic [63:0] operand_b,
    input  wire logic [6:0]  width,
    input  wire logic        is_signed,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [63:0] result,
    input  wire logic [1:0]  status,
    input  wire logic [1:0]  order,
    output int               mismatch_count,
    output int               pending_count
);
    import vwalu_pkg::*;

    res_t pending_results[$];

    function automatic logic [63:0] shl64(logic [63:0] v, logic [63:0] n);
        return (n >= 64) ? 64'd0 : (v << n[5:0]);
    endfunction

    function automatic logic [63:0] shr64(logic [63:0] v, logic [63:0] n);
        return (n >= 64) ? 64'd0 : (v >> n[5:0]);
    endfunction

    function automatic logic [63:0] sext(logic [63:0] v, int w);
        logic [63:0] top;
        top = 64'd1 << (w - 1);
        return (v ^ top) - top;
    endfunction

    function automatic res_t alu_predict(logic [3:0] op, logic [63:0] ia, logic [63:0] ib,
                                         logic [6:0] iw, logic sg);
        int w;
        logic [63:0] m, a, b, r, x, y, mx, my, rm;
        logic [1:0] st, od;
        res_t o;
        w = (iw < 1) ? 1 : ((iw > MAX_WIDTH) ? MAX_WIDTH : int'(iw));
        m = (w >= 64) ? '1 : ((64'd1 << w) - 1);
        a = ia & m;
        b = ib & m;
        r = '0;
        st = ST_OK;
        od = ORD_EQ;
        case (op)
            OP_ADD:
            begin
                r = (a + b) & m;
                if (r < a) st = ST_OVERFLOW;
            end
            OP_SUB:
            begin
                r = (a - b) & m;
                if (r > a) st = ST_UNDERFLOW;
            end
            OP_MUL:
            begin
                r = (a * b) & m;
                if (a != 0 && r / a != b) st = ST_OVERFLOW;
            end
            OP_DIV, OP_MOD:
            begin
                if (b == 0)
                begin
                    r = a;
                    st = ST_DIVZERO;
                end
                else if (op == OP_DIV)
                    r = a / b;
                else if (sg)
                begin
                    x = sext(a, w);
                    y = sext(b, w);
                    mx = x[63] ? -x : x;
                    my = y[63] ? -y : y;
                    rm = mx % my;
                    r = (x[63] ? -rm : rm) & m;
                end
                else
                    r = a % b;
            end
            OP_SHL:
            begin
                r = shl64(a, b) & m;
                if (shr64(r, b) != a) st = ST_OVERFLOW;
            end
            OP_SHR:
            begin
                r = shr64(a, b);
                if (shl64(r, b) != a) st = ST_UNDERFLOW;
            end
            OP_AND: r = a & b;
            OP_XOR: r = a ^ b;
            OP_OR:  r = a | b;
            OP_NOT: r = ~a & m;
            OP_NEG: r = -a & m;
            OP_CMP:
            begin
                x = a;
                y = b;
                if (sg)
                begin
                    x = sext(a, w) ^ (64'd1 << 63);
                    y = sext(b, w) ^ (64'd1 << 63);
                end
                od = (x == y) ? ORD_EQ : ((x > y) ? ORD_GT : ORD_LT);
            end
            default: ;
        endcase
        o.r = r & m;
        o.st = st;
        o.ord = od;
        return o;
    endfunction

    assign pending_count = pending_results.size();

    always @(posedge clk)
    begin
        res_t exp_res;
        if (rst_n && in_valid && !in_stall)
            pending_results.push_back(alu_predict(opcode, operand_a, operand_b, width,
                                                  is_signed));
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected result beat: result=%h status=%0d order=%0d",
                             result, status, order);
                mismatch_count <= mismatch_count + 1;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (exp_res.r !== result || exp_res.st !== status || exp_res.ord !== order)
                begin
                    if (mismatch_count < 10)
                        $display("result mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                                 exp_res.r, exp_res.st, exp_res.ord, result, status, order);
                    mismatch_count <= mismatch_count + 1;
                end
            end
        end
    end

    initial mismatch_count = 0;
endmodule

/* sim/tb_variable_width_integer_alu_top.sv */
// Testbench top that drives stimulus into the variable width ALU and reports the verdict.
`timescale 1ns / 1ps
module tb_variable_width_integer_alu_top;
    import vwalu_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [3:0]  opcode = '0;
    logic [63:0] operand_a = '0;
    logic [63:0] operand_b = '0;
    logic [6:0]  width = 7'd1;
    logic        is_signed = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] result;
    logic [1:0]  status;
    logic [1:0]  order;
    int          mismatch_count;
    int          pending_count;

    // The receiver idles only while this flag is set; the final stretch runs with no gaps.
    bit          sink_gaps = 1'b1;
    // A long hold-off of the output side, requested by the stimulus process.
    bit          hold_sink = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    variable_width_integer_alu_top u_top (.*);

    vwalu_checker u_chk (.*);

    // Reduce a random pattern to a width; operands arrive already reduced.
    function automatic logic [63:0] trim(logic [63:0] v, logic [6:0] w);
        return (w >= 64) ? v : (v & ((64'd1 << w) - 1));
    endfunction

    // Offer one beat and hold it until the block takes it. Valid stays high between
    // back-to-back beats, so it is never lowered and raised in the same step.
    task automatic send_beat(logic [3:0] op, logic [63:0] a, logic [63:0] b,
                             logic [6:0] w, logic sg);
        in_valid  <= 1'b1;
        opcode    <= op;
        operand_a <= trim(a, w);
        operand_b <= trim(b, w);
        width     <= w;
        is_signed <= sg;
        do @(posedge clk); while (in_stall);
    endtask

    // Drop valid for a gap of random length.
    task automatic source_gap();
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
    endtask

    // Operand patterns weighted toward the corners where the flags change.
    function automatic logic [63:0] pick_operand(logic [6:0] w);
        logic [63:0] mx;
        mx = (w >= 64) ? '1 : ((64'd1 << w) - 1);
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1: return 64'd1;
            2: return mx;
            3: return mx >> 1;
            4: return (mx >> 1) + 1;
            5: return {58'd0, 6'($urandom_range(0, 63))};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [6:0] pick_width();
        case ($urandom_range(0, 5))
            0: return 7'd1;
            1: return 7'd64;
            2: return 7'($urandom_range(1, 8));
            default: return 7'($urandom_range(1, 64));
        endcase
    endfunction

    // Receiver: random stall bursts, plus the long hold-off when asked.
    always @(posedge clk)
    begin
        if (hold_sink)
            out_stall <= 1'b1;
        else if (sink_gaps && $urandom_range(0, 5) == 0)
            out_stall <= ~out_stall;
        else if (!sink_gaps)
            out_stall <= 1'b0;
    end

    // Long hold-off, counted in cycles in its own process.
    initial
    begin
        wait (rst_n);
        repeat (300) @(posedge clk);
        hold_sink <= 1'b1;
        repeat (200) @(posedge clk);
        hold_sink <= 1'b0;
    end

    initial
    begin
        logic [6:0] w;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats: every opcode at the width extremes, then the special cases.
        for (int op = 0; op <= 12; op++)
            send_beat(4'(op), '1, 64'd1, (op % 2) ? 7'd64 : 7'd1, 1'(op % 2));
        send_beat(OP_DIV, 64'd5, 64'd0, 7'd8, 1'b0);          // divide by zero
        send_beat(OP_MOD, 64'h80, 64'hFF, 7'd8, 1'b1);        // signed minimum mod minus one
        send_beat(OP_MOD, 64'hF9, 64'd3, 7'd8, 1'b1);         // negative dividend keeps sign
        send_beat(OP_SHL, 64'd1, 64'hFFFF, 7'd16, 1'b0);      // shift by 64 or more
        send_beat(OP_SHR, '1, 64'd64, 7'd64, 1'b0);
        send_beat(OP_CMP, 64'h80, 64'h7F, 7'd8, 1'b1);        // signed compare flips order
        send_beat(OP_CMP, 64'h80, 64'h7F, 7'd8, 1'b0);
        send_beat(4'd13, '1, '1, 7'd64, 1'b1);                // unused opcode
        send_beat(4'd15, '1, '1, 7'd0, 1'b0);                 // width of zero
        send_beat(OP_ADD, '1, '1, 7'd127, 1'b0);              // width above the maximum
        send_beat(OP_MUL, 64'h1_0000_0000, 64'h1_0000_0000, 7'd64, 1'b0);

        // Random beats; the sender keeps offering while the receiver is held off.
        for (int i = 0; i < 1650; i++)
        begin
            if (i == 1000)
            begin
                // Pause the sender until every expected result has come back.
                in_valid <= 1'b0;
                while (pending_count != 0) @(posedge clk);
            end
            if (i == 1400)
                sink_gaps = 1'b0;
            if (i < 1400 && !hold_sink && $urandom_range(0, 7) == 0)
                source_gap();
            w = ($urandom_range(0, 30) == 0) ? 7'($urandom) : pick_width();
            send_beat(4'($urandom_range(0, 15)), pick_operand(w), pick_operand(w), w,
                      1'($urandom));
        end
        in_valid <= 1'b0;

        while (pending_count != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end
endmodule
